// File: hdl/rational_continued_fraction_assert.svh
// Assertion macros shared by the checker of the continued-fraction block.
// Depends on nothing; the using module supplies clk and arst_n.
`ifndef RATIONAL_CONTINUED_FRACTION_ASSERT_SVH
`define RATIONAL_CONTINUED_FRACTION_ASSERT_SVH

// Same-cycle implication
`define CFE_ASSERT_NOW(label, cond, conseq, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (conseq)) \
		else $error(msg);

// Next-cycle implication
`define CFE_ASSERT_NEXT(label, cond, conseq, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (conseq)) \
		else $error(msg);

`endif

// File: hdl/cfe_pkg.sv
// Package for the continued-fraction block: widths, limits and FSM type.
// No dependencies.
package cfe_pkg;
	localparam int WIDTH     = 32;            // signed range of a convergent
	localparam int DATA_W    = 32;            // field width
	localparam int MPLIER_W  = DATA_W + 1;    // partial quotient with headroom
	localparam int MAX_ITEMS = 48;
	localparam int CNT_W     = 6;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_DIV  = 4'b0010,
		ST_MUL  = 4'b0100,
		ST_EMIT = 4'b1000
	} state_t;
endpackage

// File: hdl/cfe_div.sv
// Bit-serial restoring divider: unsigned quotient and remainder, one bit a cycle.
// Depends on cfe_pkg.
module cfe_div import cfe_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [DATA_W-1:0] dividend,
	input  logic [DATA_W-1:0] divisor,
	output logic              done,
	output logic [DATA_W-1:0] quot,
	output logic [DATA_W-1:0] rmd
);
	logic              busy_q, done_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [DATA_W-1:0] dq_q, rem_q, dvs_q;
	logic [DATA_W:0]   shifted, diff;
	logic              ge;

	// shift one dividend bit into the partial remainder, trial-subtract
	assign shifted = {rem_q, dq_q[DATA_W-1]};
	assign diff    = shifted - {1'b0, dvs_q};
	assign ge      = shifted >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(DATA_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dq_q  <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			dq_q  <= {dq_q[DATA_W-2:0], ge};
			rem_q <= ge ? diff[DATA_W-1:0] : shifted[DATA_W-1:0];
		end
	end

	assign done = done_q;
	assign quot = dq_q;
	assign rmd  = rem_q;
endmodule

// File: hdl/cfe_mac.sv
// Bit-serial signed multiply-add: res = mplier * mcand + addend, with range check.
// Depends on cfe_pkg.
module cfe_mac import cfe_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [MPLIER_W-1:0] mplier,
	input  logic [DATA_W-1:0]   mcand,
	input  logic [DATA_W-1:0]   addend,
	output logic                done,
	output logic [DATA_W-1:0]   res,
	output logic                fits
);
	localparam int HI_W   = DATA_W + 2;
	localparam int PROD_W = HI_W + MPLIER_W;

	logic                busy_q, done_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [HI_W-1:0]     hi_q;
	logic [MPLIER_W-1:0] lo_q;
	logic [DATA_W-1:0]   m_q, add_q;
	logic [HI_W:0]       ext_m, part, sum;
	logic [PROD_W-1:0]   full;

	assign ext_m = {{(HI_W + 1 - DATA_W){m_q[DATA_W-1]}}, m_q};
	// top multiplier bit carries negative weight
	always_comb begin
		if (!lo_q[0])
			part = '0;
		else if (cnt_q == CNT_W'(MPLIER_W - 1))
			part = -ext_m;
		else
			part = ext_m;
	end
	assign sum = {hi_q[HI_W-1], hi_q} + part;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(MPLIER_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			hi_q  <= '0;
			lo_q  <= mplier;
			m_q   <= mcand;
			add_q <= addend;
		end else if (busy_q) begin
			hi_q <= sum[HI_W:1];
			lo_q <= {sum[0], lo_q[MPLIER_W-1:1]};
		end
	end

	assign full = {hi_q, lo_q} + {{(PROD_W - DATA_W){add_q[DATA_W-1]}}, add_q};
	assign fits = (&full[PROD_W-1:WIDTH-1]) | ~(|full[PROD_W-1:WIDTH-1]);
	assign res  = full[DATA_W-1:0];
	assign done = done_q;
endmodule

// File: hdl/rational_continued_fraction.sv
// Continued-fraction expansion of p/q with convergents, one result per term.
// Per term: a serial divide, then a serial multiply-add for the convergents, then an
// emit that waits for the output to be free; the multiply-add is skipped once tracking
// has dropped. A zero denominator goes straight to emit with a single error result.
// Throughput: one request at a time, up to 48 terms; in_ready returns after the last emit.
// Reset: arst_n clears the FSM, counters and output valid asynchronously.
module rational_continued_fraction import cfe_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [DATA_W-1:0] numerator,
	input  logic [DATA_W-1:0] denominator,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [DATA_W-1:0] term,
	output logic [DATA_W-1:0] conv_num,
	output logic [DATA_W-2:0] conv_den,
	output logic              conv_valid,
	output logic              div_zero,
	output logic              last
);
	state_t state_q;

	// Euclid remainders: rem_num_q may be negative only on the first step
	logic [MPLIER_W-1:0] rem_num_q;
	logic [DATA_W-1:0]   rem_den_q;
	logic [MPLIER_W-1:0] a_q;
	logic [DATA_W-1:0]   r_q;
	// convergent recurrence: h_{i-1}, h_{i-2}, k_{i-1}, k_{i-2}
	logic [DATA_W-1:0]   hp1_q, hp2_q, kp1_q, kp2_q;
	logic                conv_ok_q, dz_q;
	logic [CNT_W-1:0]    cnt_q;

	// output register
	logic                out_valid_q, conv_valid_q, div_zero_q, last_q;
	logic [DATA_W-1:0]   term_q, conv_num_q;
	logic [DATA_W-2:0]   conv_den_q;

	logic                accept, out_free, emit;
	logic [MPLIER_W-1:0] p_ext, p_fix;
	logic [DATA_W-1:0]   q_fix;
	logic                div_start, div_done;
	logic [DATA_W-1:0]   div_dvd, div_dvs, div_quot, div_rmd;
	logic [MPLIER_W-1:0] a_nxt;
	logic [DATA_W-1:0]   r_nxt;
	logic                mac_start, h_done, k_done, h_fits, k_fits;
	logic [DATA_W-1:0]   h_res, k_res;
	logic                conv_keep, run_end;
	logic [CNT_W-1:0]    cnt_nxt;

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid & in_ready;
	assign out_free = ~out_valid_q | out_ready;
	assign emit     = (state_q == ST_EMIT) & out_free;

	// move the sign into the numerator so the denominator is positive
	assign p_ext = {numerator[DATA_W-1], numerator};
	assign p_fix = denominator[DATA_W-1] ? -p_ext : p_ext;
	assign q_fix = denominator[DATA_W-1] ? -denominator : denominator;

	// start the divider on the first term of a request or on each further term
	always_comb begin
		div_dvd   = p_fix[MPLIER_W-1] ? DATA_W'(-p_fix) : p_fix[DATA_W-1:0];
		div_dvs   = q_fix;
		div_start = 1'b0;
		if (accept && denominator != '0)
			div_start = 1'b1;
		if (emit && !dz_q && !run_end) begin
			div_start = 1'b1;
			div_dvd   = rem_den_q;
			div_dvs   = r_q;
		end
	end

	cfe_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dvd),
		.divisor  (div_dvs),
		.done     (div_done),
		.quot     (div_quot),
		.rmd      (div_rmd)
	);

	// floor correction for a negative dividend
	always_comb begin
		if (!rem_num_q[MPLIER_W-1]) begin
			a_nxt = {1'b0, div_quot};
			r_nxt = div_rmd;
		end else if (div_rmd == '0) begin
			a_nxt = -{1'b0, div_quot};
			r_nxt = '0;
		end else begin
			a_nxt = ~{1'b0, div_quot};
			r_nxt = rem_den_q - div_rmd;
		end
	end

	// skip the multiply-add once a convergent has overflowed
	assign mac_start = (state_q == ST_DIV) & div_done & conv_ok_q;

	cfe_mac u_mac_h (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mac_start),
		.mplier (a_nxt),
		.mcand  (hp1_q),
		.addend (hp2_q),
		.done   (h_done),
		.res    (h_res),
		.fits   (h_fits)
	);

	cfe_mac u_mac_k (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mac_start),
		.mplier (a_nxt),
		.mcand  (kp1_q),
		.addend (kp2_q),
		.done   (k_done),
		.res    (k_res),
		.fits   (k_fits)
	);

	assign conv_keep = conv_ok_q & h_fits & k_fits;
	assign cnt_nxt   = cnt_q + 1'b1;
	assign run_end   = (r_q == '0) | (cnt_nxt >= CNT_W'(MAX_ITEMS));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			conv_ok_q   <= 1'b1;
			dz_q        <= 1'b0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// hold the result until it is taken
			if (emit)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						conv_ok_q <= 1'b1;
						cnt_q     <= '0;
						dz_q      <= (denominator == '0);
						state_q   <= (denominator == '0) ? ST_EMIT : ST_DIV;
					end
				end
				ST_DIV: begin
					if (div_done)
						state_q <= conv_ok_q ? ST_MUL : ST_EMIT;
				end
				ST_MUL: begin
					if (h_done && k_done)
						state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (out_free) begin
						cnt_q <= cnt_nxt;
						// drop convergent tracking for the rest of the run on overflow
						if (!dz_q && !conv_keep)
							conv_ok_q <= 1'b0;
						state_q <= (dz_q || run_end) ? ST_IDLE : ST_DIV;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (accept) begin
			rem_num_q <= p_fix;
			rem_den_q <= q_fix;
			hp1_q     <= DATA_W'(1);
			hp2_q     <= '0;
			kp1_q     <= '0;
			kp2_q     <= DATA_W'(1);
		end
		if (state_q == ST_DIV && div_done) begin
			a_q <= a_nxt;
			r_q <= r_nxt;
		end
		if (emit) begin
			// advance the remainders and hold the new convergent if it fits
			rem_num_q <= {1'b0, rem_den_q};
			rem_den_q <= r_q;
			if (conv_keep) begin
				hp2_q <= hp1_q;
				hp1_q <= h_res;
				kp2_q <= kp1_q;
				kp1_q <= k_res;
			end
			if (dz_q) begin
				term_q       <= '0;
				conv_num_q   <= '0;
				conv_den_q   <= '0;
				conv_valid_q <= 1'b0;
				div_zero_q   <= 1'b1;
				last_q       <= 1'b1;
			end else begin
				term_q       <= a_q[DATA_W-1:0];
				conv_num_q   <= conv_keep ? h_res : '0;
				conv_den_q   <= conv_keep ? k_res[DATA_W-2:0] : '0;
				conv_valid_q <= conv_keep;
				div_zero_q   <= 1'b0;
				last_q       <= run_end;
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign term       = term_q;
	assign conv_num   = conv_num_q;
	assign conv_den   = conv_den_q;
	assign conv_valid = conv_valid_q;
	assign div_zero   = div_zero_q;
	assign last       = last_q;
endmodule

// File: hdl/cfe_checker.sv
// Port-level checker for the continued-fraction block, bound to the top level.
// Depends on cfe_pkg and rational_continued_fraction_assert.svh.
`include "rational_continued_fraction_assert.svh"
module cfe_checker import cfe_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_ready,
	input logic [DATA_W-1:0] numerator,
	input logic [DATA_W-1:0] denominator,
	input logic              out_valid,
	input logic              out_ready,
	input logic [DATA_W-1:0] term,
	input logic [DATA_W-1:0] conv_num,
	input logic [DATA_W-2:0] conv_den,
	input logic              conv_valid,
	input logic              div_zero,
	input logic              last
);
	`CFE_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(term) && $stable(last), "result changed while stalled")
	`CFE_ASSERT_NOW(a_dz_form, out_valid && div_zero, last && !conv_valid && term == '0, "malformed division error result")
	`CFE_ASSERT_NOW(a_conv_zero, out_valid && !conv_valid, conv_num == '0 && conv_den == '0, "convergent not cleared after overflow")
	`CFE_ASSERT_NEXT(a_one_req, in_valid && in_ready, !in_ready, "second request taken during a run")
endmodule

bind rational_continued_fraction cfe_checker u_cfe_checker (.*);

// File: dv/cfe_result_checker.sv
// Checker for the continued-fraction block: watches both channels, predicts
// the term and convergent sequence of each request and compares field by field.
// Depends on cfe_pkg for the field widths and the convergent range.
`timescale 1ns / 100ps

module cfe_result_checker import cfe_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_ready,
	input  logic [DATA_W-1:0] numerator,
	input  logic [DATA_W-1:0] denominator,
	input  logic              out_valid,
	input  logic              out_ready,
	input  logic [DATA_W-1:0] term,
	input  logic [DATA_W-1:0] conv_num,
	input  logic [DATA_W-2:0] conv_den,
	input  logic              conv_valid,
	input  logic              div_zero,
	input  logic              last,
	output int                fails,
	output int                pending
);
	typedef struct packed {
		logic [DATA_W-1:0] term;
		logic [DATA_W-1:0] conv_num;
		logic [DATA_W-2:0] conv_den;
		logic              conv_valid;
		logic              div_zero;
		logic              last;
	} cfe_result_t;

	cfe_result_t expected_terms[$];

	assign pending = expected_terms.size();

	function automatic bit in_conv_range(longint v);
		longint hi;
		hi = (longint'(1) << (WIDTH - 1)) - 1;
		return v >= -hi - 1 && v <= hi;
	endfunction

	// Expand p/q and queue one expected result per partial quotient.
	task automatic expand_fraction(logic [DATA_W-1:0] num_bits, logic [DATA_W-1:0] den_bits);
		longint      p, q, a, r, h, k, h1, h2, k1, k2;
		bit          tracking;
		int          count;
		cfe_result_t res;
		p = longint'($signed(num_bits));
		q = longint'($signed(den_bits));
		if (q == 0) begin
			res = '0;
			res.div_zero = 1'b1;
			res.last = 1'b1;
			expected_terms.insert(expected_terms.size(), res);
			return;
		end
		if (q < 0) begin
			p = -p;
			q = -q;
		end
		h1 = 1; h2 = 0; k1 = 0; k2 = 1;
		tracking = 1'b1;
		count = 0;
		do begin
			a = p / q;
			if (p % q != 0 && p < 0)
				a = a - 1;
			r = p - a * q;
			res = '0;
			if (tracking) begin
				h = a * h1 + h2;
				k = a * k1 + k2;
				if (in_conv_range(h) && in_conv_range(k)) begin
					h2 = h1; h1 = h;
					k2 = k1; k1 = k;
					res.conv_num = h[DATA_W-1:0];
					res.conv_den = k[DATA_W-2:0];
				end else begin
					tracking = 1'b0;
				end
			end
			p = q;
			q = r;
			count++;
			res.term = a[DATA_W-1:0];
			res.conv_valid = tracking;
			res.last = (q == 0 || count >= MAX_ITEMS);
			expected_terms.insert(expected_terms.size(), res);
		end while (!res.last);
	endtask

	task automatic report_mismatch(string what, logic [DATA_W-1:0] got, logic [DATA_W-1:0] want);
		$display("[%0t] mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
		fails++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		cfe_result_t want;
		if (!arst_n) begin
			expected_terms.delete();
			fails = 0;
		end else begin
			if (in_valid && in_ready)
				expand_fraction(numerator, denominator);
			if (out_valid && out_ready) begin
				if (expected_terms.size() == 0) begin
					report_mismatch("unexpected result term", term, '0);
				end else begin
					want = expected_terms.pop_front();
					if (term !== want.term)
						report_mismatch("term", term, want.term);
					if (conv_num !== want.conv_num)
						report_mismatch("conv_num", conv_num, want.conv_num);
					if (conv_den !== want.conv_den)
						report_mismatch("conv_den", DATA_W'(conv_den),
							DATA_W'(want.conv_den));
					if (conv_valid !== want.conv_valid)
						report_mismatch("conv_valid", DATA_W'(conv_valid),
							DATA_W'(want.conv_valid));
					if (div_zero !== want.div_zero)
						report_mismatch("div_zero", DATA_W'(div_zero),
							DATA_W'(want.div_zero));
					if (last !== want.last)
						report_mismatch("last", DATA_W'(last), DATA_W'(want.last));
				end
			end
		end
	end
endmodule

// File: dv/tb_rational_continued_fraction.sv
// Testbench top for rational_continued_fraction: drives fraction requests,
// throttles the result side and gives the verdict. Needs cfe_pkg and
// cfe_result_checker, which predicts and compares the results.
`timescale 1ns / 100ps

module tb_rational_continued_fraction;
	import cfe_pkg::*;

	localparam int RANDOM_FRACTIONS = 92;
	localparam int QUIET_TAIL       = 25;   // final requests sent without any idling
	localparam int SETTLE_CYCLES    = 200;
	localparam int MAX_POS          = 32'h7fff_ffff;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_ready;
	logic [DATA_W-1:0] numerator = '0;
	logic [DATA_W-1:0] denominator = '0;
	logic              out_valid;
	logic              out_ready = 1'b0;
	logic [DATA_W-1:0] term;
	logic [DATA_W-1:0] conv_num;
	logic [DATA_W-2:0] conv_den;
	logic              conv_valid;
	logic              div_zero;
	logic              last;
	int                fails;
	int                pending;
	bit                idling_on = 1'b1;
	int                stall_left = 0;

	always #5 clk = ~clk;

	rational_continued_fraction uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.numerator(numerator), .denominator(denominator),
		.out_valid(out_valid), .out_ready(out_ready),
		.term(term), .conv_num(conv_num), .conv_den(conv_den),
		.conv_valid(conv_valid), .div_zero(div_zero), .last(last)
	);

	cfe_result_checker checker_i (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.numerator(numerator), .denominator(denominator),
		.out_valid(out_valid), .out_ready(out_ready),
		.term(term), .conv_num(conv_num), .conv_den(conv_den),
		.conv_valid(conv_valid), .div_zero(div_zero), .last(last),
		.fails(fails), .pending(pending)
	);

	// Result side: stall in random bursts while idling is enabled.
	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			out_ready <= 1'b0;
		end else if (idling_on && $urandom_range(0, 5) == 0) begin
			stall_left <= $urandom_range(0, 13);
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	// Offer one request; hold it until the block takes it. An optional idle
	// burst goes first, with valid dropped for its whole length.
	task automatic send_fraction(int p, int q);
		if (idling_on && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
		in_valid <= 1'b1;
		numerator <= p;
		denominator <= q;
		do @(negedge clk); while (!in_ready);
		@(posedge clk);
	endtask

	// Draw an operand: small half the time, full range otherwise, never the most negative value.
	function automatic int pick_operand();
		int v;
		case ($urandom_range(0, 3))
			0: v = $urandom_range(0, 40) - 20;
			1: v = $urandom_range(0, 200000) - 100000;
			default: begin
				v = $urandom;
				if (v == 32'h8000_0000)
					v = -MAX_POS;
			end
		endcase
		return v;
	endfunction

	initial begin
		int p, q;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: zero, division by zero, operand extremes, sign handling,
		// a long Fibonacci run and integer results.
		send_fraction(0, 1);
		send_fraction(1, 0);
		send_fraction(0, 0);
		send_fraction(-MAX_POS, 0);
		send_fraction(MAX_POS, 1);
		send_fraction(-MAX_POS, 1);
		send_fraction(MAX_POS, -1);
		send_fraction(-MAX_POS, -MAX_POS);
		send_fraction(1, MAX_POS);
		send_fraction(-1, MAX_POS);
		send_fraction(1, -MAX_POS);
		send_fraction(7, -3);
		send_fraction(-7, 3);
		send_fraction(-6, 3);
		send_fraction(1836311903, 1134903170);
		send_fraction(-1134903170, 1836311903);
		send_fraction(MAX_POS, MAX_POS - 1);
		send_fraction(MAX_POS - 1, MAX_POS);

		// Hold the sender until every outstanding result has drained; the
		// extra edge lets the checker queue the last request first.
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);

		for (int i = 0; i < RANDOM_FRACTIONS; i++) begin
			if (i == RANDOM_FRACTIONS - QUIET_TAIL)
				idling_on = 1'b0;
			p = pick_operand();
			q = ($urandom_range(0, 19) == 0) ? 0 : pick_operand();
			send_fraction(p, q);
		end
		in_valid <= 1'b0;

		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (fails == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	// Watchdog, sized for long expansions with the worst stalls on both sides.
	initial begin
		#30ms;
		$display("Regression FAIL");
		$finish;
	end
endmodule
